FILE: src/alle_pkg.sv
// ----------------------------------------------------------------------------
// alle_pkg
// Shared sizes, codes and word types of the array linked list engine.
// ----------------------------------------------------------------------------
package alle_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int VAL_W = 32;
  localparam int OP_W  = 3;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [IDX_W-1:0]        position;
    logic signed [VAL_W-1:0] node_value;
    logic [CNT_W-1:0]        element_count;
    logic                    is_empty;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic             full;
    logic [IDX_W-1:0] slot;
  } free_info_t;

endpackage

FILE: src/alle_ram.sv
// ----------------------------------------------------------------------------
// alle_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module alle_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/alle_free_find.sv
// ----------------------------------------------------------------------------
// alle_free_find
// Priority encoder: lowest slot whose used bit is clear, or a full flag.
// ----------------------------------------------------------------------------
module alle_free_find (
  input  logic [alle_pkg::SLOTS-1:0] used,
  output alle_pkg::free_info_t       info
);

  always_comb begin
    info.full = 1'b1;
    info.slot = '0;
    // scan downward so the lowest free slot wins
    for (int i = alle_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        info.full = 1'b0;
        info.slot = alle_pkg::IDX_W'(i);
      end
    end
  end

endmodule

FILE: src/array_linked_list_engine.sv
// ----------------------------------------------------------------------------
// array_linked_list_engine
// Singly linked list held in a slot table: insert, remove, modify, search.
// ----------------------------------------------------------------------------
// Insert and query count stay in the idle state: busy stays low and the single
// result word appears on the cycle after start. Remove, modify and search walk
// the list one node per cycle through the value and link RAMs, so busy is high
// while up to node_count nodes are visited, and in S_FIN when a search matches
// on the tail after an earlier match; an empty list answers at once. Results
// are presented for exactly one cycle with out_valid and cannot be held off;
// a search yields one word per match, at most one per cycle, with last set on
// the final word of each command. No clearing pass is needed after reset.
module array_linked_list_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  alle_pkg::in_word_t   in_data,
  output logic                 out_valid,
  output alle_pkg::out_word_t  out_data
);

  localparam int SLOTS = alle_pkg::SLOTS;
  localparam int IDX_W = alle_pkg::IDX_W;
  localparam int CNT_W = alle_pkg::CNT_W;
  localparam int VAL_W = alle_pkg::VAL_W;
  localparam int OP_W  = alle_pkg::OP_W;
  localparam int ST_W  = alle_pkg::ST_W;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SLOTS-1:0]    used_r, used_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [VAL_W-1:0]    key_r, key_nxt;
  logic [VAL_W-1:0]    nv_r, nv_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    prev_r, prev_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]    pend_pos_r, pend_pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  alle_pkg::out_word_t out_data_r, out_data_nxt;

  logic                val_we;
  logic [IDX_W-1:0]    val_wa;
  logic [VAL_W-1:0]    val_wd;
  logic [VAL_W-1:0]    val_rd;
  logic                lnk_we;
  logic [IDX_W-1:0]    lnk_wa;
  logic [IDX_W-1:0]    lnk_wd;
  logic [IDX_W-1:0]    lnk_rd;
  logic [IDX_W-1:0]    raddr;

  alle_pkg::free_info_t free;
  logic                 match;
  logic                 at_end;
  logic [CNT_W-1:0]     cnt_dec;

  alle_free_find u_free (
    .used (used_r),
    .info (free)
  );

  alle_ram #(.DEPTH(SLOTS), .WIDTH(VAL_W)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_wa),
    .wdata (val_wd),
    .raddr (raddr),
    .rdata (val_rd)
  );

  alle_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_wa),
    .wdata (lnk_wd),
    .raddr (raddr),
    .rdata (lnk_rd)
  );

  function automatic alle_pkg::out_word_t make_out(
    input logic [ST_W-1:0]  st,
    input logic [IDX_W-1:0] pos,
    input logic [VAL_W-1:0] val,
    input logic [CNT_W-1:0] cnt,
    input logic             lst
  );
    alle_pkg::out_word_t o;
    o.status        = st;
    o.position      = pos;
    o.node_value    = val;
    o.element_count = cnt;
    o.is_empty      = (cnt == '0);
    o.last          = lst;
    return o;
  endfunction

  assign match   = (val_rd == key_r);
  assign at_end  = ((k_r + CNT_W'(1)) == count_r);
  assign cnt_dec = count_r - CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    nv_nxt        = nv_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    k_nxt         = k_r;
    pend_vld_nxt  = pend_vld_r;
    pend_pos_nxt  = pend_pos_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    val_we        = 1'b0;
    val_wa        = idx_r;
    val_wd        = nv_r;
    lnk_we        = 1'b0;
    lnk_wa        = tail_r;
    lnk_wd        = free.slot;
    raddr         = lnk_rd;

    unique case (state_r)
      S_IDLE: begin
        raddr = head_r;
        if (start) begin
          out_valid_nxt = 1'b1;
          unique case (in_data.op)
            alle_pkg::OP_INSERT: begin
              if (free.full) begin
                out_data_nxt = make_out(alle_pkg::ST_FULL, '0, '0, count_r, 1'b1);
              end else begin
                val_we = 1'b1;
                val_wa = free.slot;
                val_wd = in_data.value;
                // link after the old tail, or start a fresh list
                if (count_r != '0) begin
                  lnk_we = 1'b1;
                end else begin
                  head_nxt = free.slot;
                end
                tail_nxt            = free.slot;
                used_nxt[free.slot] = 1'b1;
                count_nxt           = count_r + CNT_W'(1);
                out_data_nxt = make_out(alle_pkg::ST_OK, free.slot, in_data.value,
                                        count_r + CNT_W'(1), 1'b1);
              end
            end
            alle_pkg::OP_REMOVE, alle_pkg::OP_MODIFY, alle_pkg::OP_SEARCH: begin
              if (count_r == '0) begin
                out_data_nxt = make_out(alle_pkg::ST_NOT_FOUND, '0, '0, count_r, 1'b1);
              end else begin
                out_valid_nxt = 1'b0;
                op_nxt        = in_data.op;
                key_nxt       = in_data.value;
                nv_nxt        = in_data.new_value;
                idx_nxt       = head_r;
                prev_nxt      = head_r;
                k_nxt         = '0;
                pend_vld_nxt  = 1'b0;
                state_nxt     = S_WALK;
              end
            end
            default: begin
              out_data_nxt = make_out(alle_pkg::ST_OK, '0, '0, count_r, 1'b1);
            end
          endcase
        end
      end

      S_WALK: begin
        // val_rd/lnk_rd belong to idx_r; read of the following node is issued now
        prev_nxt = idx_r;
        idx_nxt  = lnk_rd;
        k_nxt    = k_r + CNT_W'(1);
        unique case (op_r)
          alle_pkg::OP_MODIFY: begin
            if (match) begin
              val_we        = 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = make_out(alle_pkg::ST_OK, idx_r, nv_r, count_r, 1'b1);
              state_nxt     = S_IDLE;
            end else if (at_end) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = make_out(alle_pkg::ST_NOT_FOUND, '0, '0, count_r, 1'b1);
              state_nxt     = S_IDLE;
            end
          end
          alle_pkg::OP_REMOVE: begin
            if (match) begin
              used_nxt[idx_r] = 1'b0;
              count_nxt       = cnt_dec;
              if (cnt_dec == '0) begin
                head_nxt = '0;
                tail_nxt = '0;
              end else begin
                if (k_r == '0) begin
                  head_nxt = lnk_rd;
                end else begin
                  lnk_we = 1'b1;
                  lnk_wa = prev_r;
                  lnk_wd = lnk_rd;
                end
                if (at_end) begin
                  tail_nxt = prev_r;
                end
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = make_out(alle_pkg::ST_OK, idx_r, key_r, cnt_dec, 1'b1);
              state_nxt     = S_IDLE;
            end else if (at_end) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = make_out(alle_pkg::ST_NOT_FOUND, '0, '0, count_r, 1'b1);
              state_nxt     = S_IDLE;
            end
          end
          alle_pkg::OP_SEARCH: begin
            // one match is held back so the final word can carry last
            if (match) begin
              pend_vld_nxt = 1'b1;
              pend_pos_nxt = idx_r;
              if (pend_vld_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = make_out(alle_pkg::ST_OK, pend_pos_r, key_r, count_r, 1'b0);
                if (at_end) begin
                  state_nxt = S_FIN;
                end
              end else if (at_end) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = make_out(alle_pkg::ST_OK, idx_r, key_r, count_r, 1'b1);
                state_nxt     = S_IDLE;
              end
            end else if (at_end) begin
              out_valid_nxt = 1'b1;
              if (pend_vld_r) begin
                out_data_nxt = make_out(alle_pkg::ST_OK, pend_pos_r, key_r, count_r, 1'b1);
              end else begin
                out_data_nxt = make_out(alle_pkg::ST_NOT_FOUND, '0, '0, count_r, 1'b1);
              end
              state_nxt = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_FIN: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = make_out(alle_pkg::ST_OK, pend_pos_r, key_r, count_r, 1'b1);
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    nv_r       <= nv_nxt;
    idx_r      <= idx_nxt;
    prev_r     <= prev_nxt;
    k_r        <= k_nxt;
    pend_pos_r <= pend_pos_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      used_r      <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
